/* design/ptdg_pkg.sv */
// package for the trial-division prime generator
// sizes, codes and reset values shared by the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package ptdg_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int VALUE_WIDTH = 16;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int BIT_W  = $clog2(VALUE_WIDTH);

  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
  localparam int FIRST_PRIME = 2;

  // result and configuration field widths
  localparam int PRIME_VALUE_W = 16;
  localparam int PRIME_INDEX_W = 10;
  localparam int PRIME_COUNT_W = 11;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_REG_PRIME_COUNT = 1'b0;
  localparam logic [PRIME_COUNT_W-1:0] PRIME_COUNT_RESET = 11'd1024;

endpackage

`default_nettype wire

/* design/prime_trial_division_generator.sv */
// prime generator by trial division: top level with sequencer and shared remainder unit
// depends on ptdg_pkg and ptdg_ram
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input stream: one transfer per request, in_tdata[0] = restart. a restart (or any
//   request while the table is empty) stores 2 and answers 2 at index 0. otherwise the
//   block answers the next prime, or done once min(max(prime_count,1),1024) primes exist.
//   output stream: one transfer per request; value and index in out_tdata, done in
//   out_tuser.
//   sequence: restart and done answers pass through S_EMIT into the output register. a
//   search tries odd candidates in turn and divides each one by the stored primes in
//   turn through one bit-serial remainder unit, stopping at the first exact divisor;
//   each division reads the table, loads the divisor and takes 16 remainder steps. a
//   search with no candidate left in 16 bits answers done. a found prime is stored and
//   loaded into the output register through S_EMIT.
//   in_tready is high only while the sequencer is idle; a finished result waits in
//   the output register, and a new request is taken meanwhile. the next result
//   leaves once the receiver has taken the previous one.
//   reset empties the table (found count 0), sets prime_count to 1024 and clears
//   the output valid. prime_count is written through the cfg apb port at address 0.

module prime_trial_division_generator
  import ptdg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,    // [0] restart
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // [15:0] prime_value, [25:16] prime_index
  output logic                       out_tuser,   // [0] done_res
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_READ,
    S_LOAD,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         found_count_r, found_count_nxt;
  logic [VALUE_WIDTH-1:0]   last_r, last_nxt;
  logic [VALUE_WIDTH:0]     cand_r, cand_nxt;
  logic [CNT_W-1:0]         j_r, j_nxt;
  logic [VALUE_WIDTH-1:0]   div_r, div_nxt;
  logic [VALUE_WIDTH-1:0]   rem_r, rem_nxt;
  logic [BIT_W-1:0]         bit_r, bit_nxt;
  logic [PRIME_VALUE_W-1:0] res_value_r, res_value_nxt;
  logic [PRIME_INDEX_W-1:0] res_index_r, res_index_nxt;
  logic                     res_done_r, res_done_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]    out_tdata_r, out_tdata_nxt;
  logic                     out_tuser_r, out_tuser_nxt;
  logic [PRIME_COUNT_W-1:0] prime_count_r;

  logic [CNT_W-1:0]         eff_count;
  logic [VALUE_WIDTH:0]     shifted;
  logic [VALUE_WIDTH-1:0]   rem_step;
  logic                     in_xfer;
  logic                     cfg_wr;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [VALUE_WIDTH-1:0]   ram_wdata;
  logic [VALUE_WIDTH-1:0]   ram_rdata;

  ptdg_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(j_r[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_REG_PRIME_COUNT) ? CFG_DATA_W'(prime_count_r)
                                                            : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_count_r <= PRIME_COUNT_RESET;
    end else if (cfg_wr && cfg_paddr[2] == CFG_REG_PRIME_COUNT) begin
      prime_count_r <= cfg_pwdata[PRIME_COUNT_W-1:0];
    end
  end

  always_comb begin
    if (prime_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(prime_count_r) > 32'(TABLE_DEPTH)) begin
      eff_count = CNT_W'(TABLE_DEPTH);
    end else begin
      eff_count = CNT_W'(prime_count_r);
    end
  end

  // one restoring remainder step
  assign shifted  = {rem_r, cand_r[bit_r]};
  assign rem_step = (shifted >= {1'b0, div_r}) ? VALUE_WIDTH'(shifted - {1'b0, div_r})
                                               : shifted[VALUE_WIDTH-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt       = state_r;
    found_count_nxt = found_count_r;
    last_nxt        = last_r;
    cand_nxt        = cand_r;
    j_nxt           = j_r;
    div_nxt         = div_r;
    rem_nxt         = rem_r;
    bit_nxt         = bit_r;
    res_value_nxt   = res_value_r;
    res_index_nxt   = res_index_r;
    res_done_nxt    = res_done_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;
    out_tuser_nxt   = out_tuser_r;
    ram_we          = 1'b0;
    ram_waddr       = found_count_r[ADDR_W-1:0];
    ram_wdata       = cand_r[VALUE_WIDTH-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tdata[0] || found_count_r == '0) begin
            ram_we          = 1'b1;
            ram_waddr       = '0;
            ram_wdata       = VALUE_WIDTH'(FIRST_PRIME);
            found_count_nxt = CNT_W'(1);
            last_nxt        = VALUE_WIDTH'(FIRST_PRIME);
            res_value_nxt   = PRIME_VALUE_W'(FIRST_PRIME);
            res_index_nxt   = '0;
            res_done_nxt    = 1'b0;
            state_nxt       = S_EMIT;
          end else if (found_count_r >= eff_count) begin
            res_value_nxt = '0;
            res_index_nxt = '0;
            res_done_nxt  = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cand_nxt  = ({1'b0, last_r} + (VALUE_WIDTH + 1)'(1)) | (VALUE_WIDTH + 1)'(1);
            state_nxt = S_CAND;
          end
        end
      end
      S_CAND: begin
        if (cand_r[VALUE_WIDTH]) begin
          last_nxt      = VALUE_MAX;
          res_value_nxt = '0;
          res_index_nxt = '0;
          res_done_nxt  = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          j_nxt     = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        div_nxt   = ram_rdata;
        rem_nxt   = '0;
        bit_nxt   = BIT_W'(VALUE_WIDTH - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = rem_step;
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          if (rem_step == '0 && div_r != '0) begin
            cand_nxt  = cand_r + (VALUE_WIDTH + 1)'(2);
            state_nxt = S_CAND;
          end else if (j_r + CNT_W'(1) == found_count_r) begin
            ram_we          = 1'b1;
            found_count_nxt = found_count_r + CNT_W'(1);
            last_nxt        = cand_r[VALUE_WIDTH-1:0];
            res_value_nxt   = PRIME_VALUE_W'(cand_r[VALUE_WIDTH-1:0]);
            res_index_nxt   = PRIME_INDEX_W'(found_count_r);
            res_done_nxt    = 1'b0;
            state_nxt       = S_EMIT;
          end else begin
            j_nxt     = j_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_DATA_W'({res_index_r, res_value_r});
          out_tuser_nxt  = res_done_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      found_count_r <= '0;
      last_r        <= VALUE_WIDTH'(FIRST_PRIME);
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      found_count_r <= found_count_nxt;
      last_r        <= last_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
    cand_r      <= cand_nxt;
    j_r         <= j_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    res_value_r <= res_value_nxt;
    res_index_r <= res_index_nxt;
    res_done_r  <= res_done_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("sequencer idle right after a request transfer");

  a_prime_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[PRIME_VALUE_W-1:0] != '0)
    else $error("prime result with zero value");

  a_later_primes_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[PRIME_VALUE_W +: PRIME_INDEX_W] != '0
    |-> out_tdata[0])
    else $error("even prime past index zero");

  a_table_write_place: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE && in_xfer) || (state_r == S_DIV && bit_r == '0))
    else $error("table written outside a restart or a found prime");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CAND |-> found_count_r < eff_count && found_count_r != '0)
    else $error("search started with table full or empty");

endmodule

`default_nettype wire

/* design/ptdg_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ptdg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sim/tb.sv */
// testbench for the trial-division prime generator: stream requests in, compares answers
// against a predictor of the prime sequence; uses ptdg_pkg and prime_trial_division_generator
`timescale 1ns / 1ps

module tb;
  import ptdg_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [PRIME_VALUE_W-1:0] prime_value;
    logic [PRIME_INDEX_W-1:0] prime_index;
    logic                     done_res;
  } prime_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // [0] restart
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // [15:0] prime_value, [25:16] prime_index
  logic                  out_tuser;   // [0] done_res
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predictor state
  int            prime_tbl [TABLE_DEPTH];
  int            found_cnt;
  int            last_cand;
  int            prime_limit;
  prime_result_t pending_primes [$];

  int mismatches;
  int snd_idle_pct;
  int rcv_stall_pct;
  int hold_cycles;
  int cycles;

  prime_trial_division_generator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic prime_result_t predict_prime(bit restart);
    prime_result_t r;
    int            lim;
    int            cand;
    bit            coprime;
    r = '0;
    lim = prime_limit;
    if (lim == 0) lim = 1;
    if (lim > TABLE_DEPTH) lim = TABLE_DEPTH;
    if (restart || found_cnt == 0) begin
      prime_tbl[0] = FIRST_PRIME;
      found_cnt = 1;
      last_cand = FIRST_PRIME;
      r.prime_value = PRIME_VALUE_W'(FIRST_PRIME);
      return r;
    end
    if (found_cnt >= lim) begin
      r.done_res = 1'b1;
      return r;
    end
    cand = last_cand + 1;
    if (cand % 2 == 0) cand++;
    while (cand <= int'(VALUE_MAX)) begin
      coprime = 1'b1;
      for (int j = 0; j < found_cnt && j < TABLE_DEPTH; j++) begin
        if (prime_tbl[j] != 0 && cand % prime_tbl[j] == 0) begin
          coprime = 1'b0;
          break;
        end
      end
      if (coprime) begin
        prime_tbl[found_cnt % TABLE_DEPTH] = cand;
        r.prime_value = PRIME_VALUE_W'(cand);
        r.prime_index = PRIME_INDEX_W'(found_cnt);
        found_cnt++;
        last_cand = cand;
        return r;
      end
      cand += 2;
    end
    last_cand = int'(VALUE_MAX);
    r.done_res = 1'b1;
    return r;
  endfunction

  // request prediction and answer checking, both on accepted transfers
  always @(posedge clk) begin
    prime_result_t exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_primes.push_back(predict_prime(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        if (pending_primes.size() == 0) begin
          $error("unexpected answer: value %0d index %0d done %0b",
                 out_tdata[15:0], out_tdata[25:16], out_tuser);
          mismatches++;
        end else begin
          exp_r = pending_primes.pop_front();
          if (out_tdata[15:0] !== exp_r.prime_value) begin
            $error("prime_value: expected %0d, actual %0d", exp_r.prime_value,
                   out_tdata[15:0]);
            mismatches++;
          end
          if (out_tdata[25:16] !== exp_r.prime_index) begin
            $error("prime_index: expected %0d, actual %0d", exp_r.prime_index,
                   out_tdata[25:16]);
            mismatches++;
          end
          if (out_tuser !== exp_r.done_res) begin
            $error("done_res: expected %0b, actual %0b", exp_r.done_res, out_tuser);
            mismatches++;
          end
        end
      end
    end
  end

  // receiver with random stalls and one long hold-off in the backpressure test
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input bit restart);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if ($urandom_range(99) < snd_idle_pct) begin
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= IN_DATA_W'(restart);
        placed = 1'b1;
      end
    end
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // lower valid, wait for every answer, then let the block settle
  task automatic drain_answers();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_prime_count(input int count);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * CFG_REG_PRIME_COUNT);
    cfg_pwdata  <= CFG_DATA_W'(count);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    prime_limit = count & 'h7FF;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(prime_limit)) begin
      $error("prime_count readback: expected %0d, actual %0d", prime_limit, cfg_prdata);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_next_before_restart();
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain_answers();
  endtask

  task automatic test_count_extremes();
    // zero acts as one
    write_prime_count(0);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    drain_answers();
    write_prime_count(1);
    send_request(1'b0);
    send_request(1'b1);
    drain_answers();
    // above the table depth acts as the depth
    write_prime_count(2047);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    drain_answers();
    // done leaves the state alone, restart works at the limit
    write_prime_count(3);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain_answers();
    write_prime_count(5);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    drain_answers();
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                     input int n_items, input int max_count);
    write_prime_count($urandom_range(1, max_count));
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    send_request(1'b1);
    for (int i = 1; i < n_items; i++)
      send_request($urandom_range(99) < 8);
    drain_answers();
  endtask

  task automatic test_backpressure();
    write_prime_count(16);
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_cycles = 400;
    send_request(1'b1);
    repeat (9) send_request(1'b0);
    drain_answers();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mismatches  = 0;
    hold_cycles = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    found_cnt   = 0;
    last_cand   = FIRST_PRIME;
    prime_limit = int'(PRIME_COUNT_RESET);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_next_before_restart();
    test_count_extremes();
    test_random_traffic(0, 0, 17, 12);
    test_random_traffic(87, 0, 17, 30);
    test_random_traffic(0, 87, 17, 20);
    test_random_traffic(36, 36, 17, 48);
    test_backpressure();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_primes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
